/* hw/rtl/tdp_pkg.sv */
`default_nettype none

package tdp_pkg;

	// Sequencer states of the prime test
	typedef enum logic [1:0] {
		S_IDLE,
		S_LOAD,
		S_DIV,
		S_DONE
	} tdp_state_t;

	// Status returned by the shared divider
	typedef struct packed {
		logic done;
		logic rem_zero;
	} tdp_div_stat_t;

endpackage

`default_nettype wire

/* hw/rtl/tdp_div.sv */
`default_nettype none

// Radix-2 restoring divider: one quotient bit per cycle.
module tdp_div #(
	parameter int W = 32
) (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  start,
	input  wire  [W-1:0]         dividend,
	input  wire  [W-1:0]         divisor,
	output logic [W-1:0]         quotient,
	output tdp_pkg::tdp_div_stat_t stat
);

	localparam int CW = $clog2(W);

	logic [W-1:0]  rem_q;
	logic [W-1:0]  quo_q;
	logic [W-1:0]  div_q;
	logic [CW-1:0] count_q;
	logic          busy_q;
	logic          done_q;

	logic [W:0]    shifted;
	logic [W:0]    div_ext;
	logic          ge;
	logic [W:0]    rem_full;

	assign shifted  = {rem_q, quo_q[W-1]};
	assign div_ext  = {1'b0, div_q};
	assign ge       = (shifted >= div_ext);
	assign rem_full = ge ? (shifted - div_ext) : shifted;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			done_q  <= 1'b0;
			count_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q  <= 1'b1;
				count_q <= '0;
			end else if (busy_q) begin
				count_q <= count_q + CW'(1);
				// last quotient bit: drop busy, flag done next cycle
				if (count_q == CW'(W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			div_q <= divisor;
		end else if (busy_q) begin
			rem_q <= rem_full[W-1:0];
			quo_q <= {quo_q[W-2:0], ge};
		end
	end

	assign quotient      = quo_q;
	assign stat.done     = done_q;
	assign stat.rem_zero = (rem_q == '0);

endmodule

`default_nettype wire

/* hw/rtl/trial_division_prime_test_unit.sv */
`default_nettype none

// Trial-division prime test.
//
// Input channel: candidate (VALUE_WIDTH bits, signed) with cand_valid / cand_stall.
// A beat is taken when cand_valid is high and cand_stall is low.
// Output channel: is_prime with res_valid / res_stall; one result beat per input beat.
//
// Negative values, 0, 1, 2 and other even values are settled in the accept
// cycle and pass through S_DONE into the output register. Odd values of 3 or
// more run through a single shared radix-2 divider: each odd divisor
// d = 3, 5, 7, ... takes a load step, VALUE_WIDTH quotient bits and a check. The
// divider's quotient gives the bound d <= n / d and its remainder the
// divisibility test, both from the same division. A 32-bit prime near the top
// of the range needs about 23170 divisors.
// One item is in work at a time: cand_stall stays high from accept until the
// result sits in the output register. A stalled result holds in that register;
// the next item may be accepted meanwhile and waits in S_DONE for it to drain.
// Reset clears the sequencer and the output valid; no state carries across items.
module trial_division_prime_test_unit #(
	parameter int VALUE_WIDTH = 32
) (
	input  wire                          clk,
	input  wire                          arst_n,
	input  wire                          cand_valid,
	output logic                         cand_stall,
	input  wire signed [VALUE_WIDTH-1:0] candidate,
	output logic                         res_valid,
	input  wire                          res_stall,
	output logic                         is_prime
);

	localparam int W = VALUE_WIDTH;

	tdp_pkg::tdp_state_t    state_q, state_d;
	logic [W-1:0]           n_q, n_d;
	logic [W-1:0]           d_q, d_d;
	logic                   res_q, res_d;
	logic                   res_valid_q;
	logic                   is_prime_q;
	logic                   div_start;
	logic                   out_load;
	logic [W-1:0]           quotient;
	tdp_pkg::tdp_div_stat_t div_stat;
	logic [W-1:0]           v;
	logic                   take;

	assign v          = candidate;
	assign cand_stall = (state_q != tdp_pkg::S_IDLE);
	assign take       = cand_valid && !cand_stall;

	tdp_div #(
		.W(W)
	) u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (div_start),
		.dividend(n_q),
		.divisor (d_q),
		.quotient(quotient),
		.stat    (div_stat)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= tdp_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk) begin
		n_q   <= n_d;
		d_q   <= d_d;
		res_q <= res_d;
	end

	always_comb begin
		state_d   = state_q;
		n_d       = n_q;
		d_d       = d_q;
		res_d     = res_q;
		div_start = 1'b0;
		out_load  = 1'b0;
		case (state_q)
			tdp_pkg::S_IDLE: begin
				if (take) begin
					n_d = v;
					d_d = W'(3);
					// settle the easy cases right away
					if (v[W-1] || v <= W'(1)) begin
						res_d   = 1'b0;
						state_d = tdp_pkg::S_DONE;
					end else if (v == W'(2)) begin
						res_d   = 1'b1;
						state_d = tdp_pkg::S_DONE;
					end else if (!v[0]) begin
						res_d   = 1'b0;
						state_d = tdp_pkg::S_DONE;
					end else begin
						state_d = tdp_pkg::S_LOAD;
					end
				end
			end
			tdp_pkg::S_LOAD: begin
				div_start = 1'b1;
				state_d   = tdp_pkg::S_DIV;
			end
			tdp_pkg::S_DIV: begin
				if (div_stat.done) begin
					if (d_q > quotient) begin
						// divisor passed the square root: no factor found
						res_d   = 1'b1;
						state_d = tdp_pkg::S_DONE;
					end else if (div_stat.rem_zero) begin
						res_d   = 1'b0;
						state_d = tdp_pkg::S_DONE;
					end else begin
						d_d     = d_q + W'(2);
						state_d = tdp_pkg::S_LOAD;
					end
				end
			end
			tdp_pkg::S_DONE: begin
				// hand the result over once the output register is free
				if (!res_valid_q || !res_stall) begin
					out_load = 1'b1;
					state_d  = tdp_pkg::S_IDLE;
				end
			end
			default: begin
				state_d = tdp_pkg::S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (out_load) begin
			res_valid_q <= 1'b1;
		end else if (!res_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			is_prime_q <= res_q;
		end
	end

	assign res_valid = res_valid_q;
	assign is_prime  = is_prime_q;

	// Divider finishes only while the sequencer waits for it
	a_done_in_div: assert property (@(posedge clk) disable iff (!arst_n)
		div_stat.done |-> state_q == tdp_pkg::S_DIV)
		else $error("divider done outside S_DIV");

	// Trial divisors stay odd
	a_odd_divisor: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == tdp_pkg::S_LOAD || state_q == tdp_pkg::S_DIV) |-> d_q[0])
		else $error("even trial divisor");

	// Accepted even values above 2 never reach the divider
	a_even_short: assert property (@(posedge clk) disable iff (!arst_n)
		(take && !v[0] && v != W'(2)) |=> state_q == tdp_pkg::S_DONE && !res_q)
		else $error("even candidate not settled at accept");

	// A pending result is never overwritten while stalled
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid_q && res_stall) |-> !out_load)
		else $error("result overwritten under stall");

endmodule

`default_nettype wire
